>>> design/mhjt_pkg.sv
// ----------------------------------------------------------------------------
// mhjt_pkg
// Shared constants, codes and types of the minimum hop jump table block.
// ----------------------------------------------------------------------------
package mhjt_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int LEVELS     = 10;

  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int POS_W      = 32;
  localparam int LIM_W      = POS_W + 1;
  localparam int FIELD_IDX_W = 10;
  localparam int FUNC_W     = 2;
  localparam int HOPS_W     = 11;
  localparam int STAT_W     = 2;

  localparam int JT_DEPTH   = MAX_POINTS * LEVELS;
  localparam int JT_AW      = $clog2(JT_DEPTH);

  localparam int IN_TDATA_W  = ((POS_W + 2 * FIELD_IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((HOPS_W + 7) / 8) * 8;

  // hop count reported when the target is out of reach
  localparam logic [HOPS_W-1:0] HOPS_SAT = HOPS_W'(64'd1 << LEVELS);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 2'd0,
    FN_BUILD = 2'd1,
    FN_QUERY = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_UNBUILT = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [POS_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } pos_req_t;

  typedef struct packed {
    logic             we;
    logic [JT_AW-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [JT_AW-1:0] raddr;
  } jt_req_t;

  typedef struct packed {
    logic             built;
    logic [CNT_W-1:0] count;
  } stat_t;

  // table entry of level k for point i, levels stacked as blocks of points
  function automatic logic [JT_AW-1:0] jt_addr(input logic [LVL_W-1:0] k,
                                               input logic [IDX_W-1:0] i);
    return JT_AW'(int'(k) * MAX_POINTS + int'(i));
  endfunction

endpackage

>>> design/min_hop_jump_table_top.sv
// ----------------------------------------------------------------------------
// min_hop_jump_table_top
// Minimum hop counts between sorted points through a binary lifting table.
// ----------------------------------------------------------------------------
// usage: set max_hop through cfg_we/cfg_wdata while idle, then stream beats
// on the s_axis side. tuser carries the function: load a position, build
// the jump table, or query the hop count between two point indices. every
// input beat gives exactly one output beat on m_axis (hops in tdata, status
// in tuser). one item is worked at a time; s_axis_tready is high only when
// the sequencer is idle, also while an earlier result still sits in the
// output register.
// item steps: a load, a build of an empty store or a rejected item goes
// straight to the result stage; a query does one jump table read per level
// plus a final check read; a build walks forward over the positions for
// each level 0 entry, then fills each upper level entry with two table
// reads and a write in turn, set by the single read port of the table
// memory. the next beat can be taken once the result has moved into the
// output register.
// reset clears the point count, built flag, max_hop and output valid; the
// memories are not cleared and need no clearing pass. if m_axis_tready stays
// low the finished result waits in the output register; one more beat can
// still be taken, and its result is held until the output register frees.
// ----------------------------------------------------------------------------
module min_hop_jump_table_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mhjt_pkg::POS_W-1:0]        cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // position, first_index, second_index, zero pad
  input  logic [mhjt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func
  input  logic [mhjt_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hops, zero pad
  output logic [mhjt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // status
  output logic [mhjt_pkg::STAT_W-1:0]       m_axis_tuser
);

  import mhjt_pkg::*;

  pos_req_t                pos_req;
  jt_req_t                 jt_req;
  stat_t                   stat;
  logic [POS_W-1:0]        pos_rdata;
  logic [IDX_W-1:0]        jt_rdata;
  logic [HOPS_W-1:0]       out_hops;

  mhjt_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_POINTS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_req.we),
    .waddr (pos_req.waddr),
    .wdata (pos_req.wdata),
    .raddr (pos_req.raddr),
    .rdata (pos_rdata)
  );

  mhjt_ram #(
    .WIDTH (IDX_W),
    .DEPTH (JT_DEPTH)
  ) u_jt_ram (
    .clk   (clk),
    .we    (jt_req.we),
    .waddr (jt_req.waddr),
    .wdata (jt_req.wdata),
    .raddr (jt_req.raddr),
    .rdata (jt_rdata)
  );

  mhjt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_position (s_axis_tdata[POS_W-1:0]),
    .in_first    (s_axis_tdata[POS_W+FIELD_IDX_W-1:POS_W]),
    .in_second   (s_axis_tdata[POS_W+2*FIELD_IDX_W-1:POS_W+FIELD_IDX_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_hops    (out_hops),
    .out_status  (m_axis_tuser),
    .pos_req     (pos_req),
    .pos_rdata   (pos_rdata),
    .jt_req      (jt_req),
    .jt_rdata    (jt_rdata),
    .stat        (stat)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_hops);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat taken while an item is in work");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_LOAD &&
     stat.count != CNT_W'(MAX_POINTS)) |=>
    (stat.count == $past(stat.count) + CNT_W'(1) && !stat.built))
    else $error("load did not advance point count");

  a_sat_hops: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_SAT) |->
    m_axis_tdata[HOPS_W-1:0] == HOPS_SAT)
    else $error("saturated result with wrong hop count");

endmodule

>>> design/mhjt_ram.sv
// ----------------------------------------------------------------------------
// mhjt_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mhjt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mhjt_ctrl.sv
// ----------------------------------------------------------------------------
// mhjt_ctrl
// Sequencer for load, table build and query, plus the result register.
// ----------------------------------------------------------------------------
module mhjt_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mhjt_pkg::POS_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mhjt_pkg::FUNC_W-1:0]  in_func,
  input  logic [mhjt_pkg::POS_W-1:0]   in_position,
  input  logic [mhjt_pkg::FIELD_IDX_W-1:0] in_first,
  input  logic [mhjt_pkg::FIELD_IDX_W-1:0] in_second,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mhjt_pkg::HOPS_W-1:0]  out_hops,
  output logic [mhjt_pkg::STAT_W-1:0]  out_status,
  output mhjt_pkg::pos_req_t           pos_req,
  input  logic [mhjt_pkg::POS_W-1:0]   pos_rdata,
  output mhjt_pkg::jt_req_t            jt_req,
  input  logic [mhjt_pkg::IDX_W-1:0]   jt_rdata,
  output mhjt_pkg::stat_t              stat
);

  import mhjt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_B0_RDI = 11'b000_0000_0010,
    S_B0_LIM = 11'b000_0000_0100,
    S_B0_CMP = 11'b000_0000_1000,
    S_BK_RDA = 11'b000_0001_0000,
    S_BK_RDB = 11'b000_0010_0000,
    S_BK_WR  = 11'b000_0100_0000,
    S_Q_RD   = 11'b000_1000_0000,
    S_Q_STEP = 11'b001_0000_0000,
    S_Q_FIN  = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                built, built_next;
  logic [POS_W-1:0]    max_hop;
  logic [IDX_W-1:0]    ii, ii_next;
  logic [IDX_W-1:0]    jj, jj_next;
  logic [LVL_W-1:0]    kk, kk_next;
  logic [LIM_W-1:0]    limit, limit_next;
  logic [IDX_W-1:0]    ww, ww_next;
  logic [IDX_W-1:0]    hi, hi_next;
  logic [LEVELS-1:0]   acc, acc_next;
  logic [HOPS_W-1:0]   res_hops, res_hops_next;
  status_t             res_status, res_status_next;

  logic                fin_entry;
  logic [IDX_W-1:0]    j_final;
  logic [CNT_W-1:0]    ii_inc;
  logic                take;
  logic [IDX_W-1:0]    w_step;
  logic                emit_go;

  assign in_ready    = (state == S_IDLE);
  assign ii_inc      = CNT_W'(ii) + CNT_W'(1);
  assign take        = (jt_rdata < hi);
  assign w_step      = take ? jt_rdata : ww;
  assign emit_go     = (state == S_EMIT) && (!out_valid || out_ready);
  assign stat.built  = built;
  assign stat.count  = count;

  always_comb begin
    state_next      = state;
    count_next      = count;
    built_next      = built;
    ii_next         = ii;
    jj_next         = jj;
    kk_next         = kk;
    limit_next      = limit;
    ww_next         = ww;
    hi_next         = hi;
    acc_next        = acc;
    res_hops_next   = res_hops;
    res_status_next = res_status;
    pos_req         = '0;
    jt_req          = '0;
    fin_entry       = 1'b0;
    j_final         = jj;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_hops_next   = '0;
          res_status_next = ST_OK;
          state_next      = S_EMIT;
          case (in_func)
            FN_LOAD: begin
              if (count == CNT_W'(MAX_POINTS)) begin
                res_status_next = ST_RANGE;
              end else begin
                pos_req.we    = 1'b1;
                pos_req.waddr = count[IDX_W-1:0];
                pos_req.wdata = in_position;
                count_next    = count + CNT_W'(1);
                built_next    = 1'b0;
              end
            end
            FN_BUILD: begin
              if (count == '0) begin
                built_next = 1'b1;
              end else begin
                ii_next    = '0;
                state_next = S_B0_RDI;
              end
            end
            FN_QUERY: begin
              if (!built) begin
                res_status_next = ST_UNBUILT;
              end else if (CNT_W'(in_first) >= count || CNT_W'(in_second) >= count) begin
                res_status_next = ST_RANGE;
              end else begin
                if (in_first > in_second) begin
                  ww_next = IDX_W'(in_second);
                  hi_next = IDX_W'(in_first);
                end else begin
                  ww_next = IDX_W'(in_first);
                  hi_next = IDX_W'(in_second);
                end
                kk_next    = LVL_W'(LEVELS - 1);
                acc_next   = '0;
                state_next = S_Q_RD;
              end
            end
            default: begin
              res_status_next = ST_RANGE;
            end
          endcase
        end
      end

      S_B0_RDI: begin
        pos_req.raddr = ii;
        state_next    = S_B0_LIM;
      end

      S_B0_LIM: begin
        limit_next = {1'b0, pos_rdata} + {1'b0, max_hop};
        jj_next    = ii;
        if (ii_inc < count) begin
          pos_req.raddr = ii + IDX_W'(1);
          state_next    = S_B0_CMP;
        end else begin
          fin_entry = 1'b1;
          j_final   = ii;
        end
      end

      // forward walk, one position per cycle
      S_B0_CMP: begin
        if ({1'b0, pos_rdata} <= limit) begin
          jj_next = jj + IDX_W'(1);
          if (CNT_W'(jj) + CNT_W'(2) < count) begin
            pos_req.raddr = jj + IDX_W'(2);
          end else begin
            fin_entry = 1'b1;
            j_final   = jj + IDX_W'(1);
          end
        end else begin
          fin_entry = 1'b1;
          j_final   = jj;
        end
      end

      S_BK_RDA: begin
        jt_req.raddr = jt_addr(kk - LVL_W'(1), ii);
        state_next   = S_BK_RDB;
      end

      S_BK_RDB: begin
        jt_req.raddr = jt_addr(kk - LVL_W'(1), jt_rdata);
        state_next   = S_BK_WR;
      end

      S_BK_WR: begin
        jt_req.we    = 1'b1;
        jt_req.waddr = jt_addr(kk, ii);
        jt_req.wdata = jt_rdata;
        state_next   = S_BK_RDA;
        if (ii_inc == count) begin
          if (kk == LVL_W'(LEVELS - 1)) begin
            built_next = 1'b1;
            state_next = S_EMIT;
          end else begin
            kk_next = kk + LVL_W'(1);
            ii_next = '0;
          end
        end else begin
          ii_next = ii + IDX_W'(1);
        end
      end

      S_Q_RD: begin
        jt_req.raddr = jt_addr(kk, ww);
        state_next   = S_Q_STEP;
      end

      // greedy descent, one level per cycle
      S_Q_STEP: begin
        ww_next = w_step;
        if (take) begin
          acc_next = acc | (LEVELS'(1) << kk);
        end
        if (kk == '0) begin
          jt_req.raddr = jt_addr('0, w_step);
          state_next   = S_Q_FIN;
        end else begin
          kk_next      = kk - LVL_W'(1);
          jt_req.raddr = jt_addr(kk - LVL_W'(1), w_step);
        end
      end

      S_Q_FIN: begin
        if (take) begin
          res_hops_next   = HOPS_SAT;
          res_status_next = ST_SAT;
        end else begin
          res_hops_next   = HOPS_W'(acc) + HOPS_W'(1);
        end
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (emit_go) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // level 0 entry done: store it and move on
    if (fin_entry) begin
      jt_req.we    = 1'b1;
      jt_req.waddr = jt_addr('0, ii);
      jt_req.wdata = j_final;
      if (ii_inc == count) begin
        ii_next = '0;
        if (LEVELS > 1) begin
          kk_next    = LVL_W'(1);
          state_next = S_BK_RDA;
        end else begin
          built_next = 1'b1;
          state_next = S_EMIT;
        end
      end else begin
        ii_next    = ii + IDX_W'(1);
        state_next = S_B0_RDI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      built     <= 1'b0;
      max_hop   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      built <= built_next;
      if (cfg_we) begin
        max_hop <= cfg_wdata;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ii         <= ii_next;
    jj         <= jj_next;
    kk         <= kk_next;
    limit      <= limit_next;
    ww         <= ww_next;
    hi         <= hi_next;
    acc        <= acc_next;
    res_hops   <= res_hops_next;
    res_status <= res_status_next;
    if (emit_go) begin
      out_hops   <= res_hops;
      out_status <= res_status;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of min_hop_jump_table_top. Loads mostly sorted point positions, builds
// the jump table under several max_hop settings and checks every status and
// hop count beat against a scoreboard that keeps its own copy of the points
// and the lifting table, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  import mhjt_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int WATCHDOG_CYCLES = 2000000;
  localparam int IDLE_PCT        = 19;
  localparam int FILL_POINTS     = 512;
  localparam int GROW [7]        = '{10, 20, 35, 55, 80, 110, 150};

  typedef struct packed {
    logic [HOPS_W-1:0] hops;
    status_t           status;
  } hop_result_t;

  class hop_scoreboard;
    logic [POS_W-1:0] positions [MAX_POINTS];
    logic [IDX_W-1:0] jumps [JT_DEPTH];
    int unsigned      n_points;
    bit               built;
    logic [POS_W-1:0] reach;
    hop_result_t      pending [$];
    int               errors;
    int               n_items;
    int               n_checked;
    int               status_seen [4];

    function new();
      n_points  = 0;
      built     = 0;
      reach     = '0;
      errors    = 0;
      n_items   = 0;
      n_checked = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    // level 0 walks forward while in reach, upper levels compose the one below
    function void rebuild();
      logic [LIM_W-1:0] lim;
      int unsigned      j;
      for (int unsigned i = 0; i < n_points; i++) begin
        lim = {1'b0, positions[i]} + {1'b0, reach};
        j = i;
        while (j + 1 < n_points && {1'b0, positions[j + 1]} <= lim) j++;
        jumps[i * LEVELS] = IDX_W'(j);
      end
      for (int k = 1; k < LEVELS; k++)
        for (int unsigned i = 0; i < n_points; i++)
          jumps[i * LEVELS + k] = jumps[int'(jumps[i * LEVELS + k - 1]) * LEVELS + k - 1];
      built = 1;
    endfunction

    function hop_result_t predict(logic [FUNC_W-1:0] fn, logic [IN_TDATA_W-1:0] data);
      hop_result_t r;
      int unsigned lo, hi, w, nxt, cnt;
      r.hops   = '0;
      r.status = ST_OK;
      case (fn)
        FN_LOAD: begin
          if (n_points >= MAX_POINTS) begin
            r.status = ST_RANGE;
          end else begin
            positions[n_points] = data[POS_W-1:0];
            n_points++;
            built = 0;
          end
        end
        FN_BUILD: rebuild();
        FN_QUERY: begin
          lo = 32'(data[POS_W +: FIELD_IDX_W]);
          hi = 32'(data[POS_W + FIELD_IDX_W +: FIELD_IDX_W]);
          if (!built) begin
            r.status = ST_UNBUILT;
          end else if (lo >= n_points || hi >= n_points) begin
            r.status = ST_RANGE;
          end else begin
            if (lo > hi) begin
              w  = lo;
              lo = hi;
              hi = w;
            end
            w   = lo;
            cnt = 0;
            // greedy descent: take every jump that stays short of the target
            for (int k = LEVELS - 1; k >= 0; k--) begin
              nxt = 32'(jumps[w * LEVELS + k]);
              if (nxt < hi) begin
                cnt += 1 << k;
                w = nxt;
              end
            end
            if (jumps[w * LEVELS] < hi) begin
              r.hops   = HOPS_SAT;
              r.status = ST_SAT;
            end else begin
              r.hops = HOPS_W'(cnt + 1);
            end
          end
        end
        default: r.status = ST_RANGE;
      endcase
      return r;
    endfunction

    function void note_item(logic [FUNC_W-1:0] fn, logic [IN_TDATA_W-1:0] data);
      pending.insert(pending.size(), predict(fn, data));
      n_items++;
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic [STAT_W-1:0] user);
      hop_result_t e;
      n_checked++;
      if (pending.size() == 0) begin
        flag("unexpected result beat, hops", -1, int'(data));
        return;
      end
      e = pending.pop_front();
      status_seen[int'(e.status)]++;
      if (data !== OUT_TDATA_W'(e.hops)) flag("hops", int'(e.hops), int'(data));
      if (user !== e.status) flag("status", int'(e.status), int'(user));
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [POS_W-1:0]       cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;

  bit               steady = 0;
  int               quiet_cycles = 0;
  logic [POS_W-1:0] cursor = '0;
  logic [POS_W-1:0] step = 32'd1;
  hop_scoreboard    sb;

  min_hop_jump_table_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side: check beats, stall at random, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("[min_hop_jump_table_top] ERROR");
        $finish;
      end
    end
  end

  task automatic send_beat(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                           logic [FIELD_IDX_W-1:0] a, logic [FIELD_IDX_W-1:0] b);
    logic [IN_TDATA_W-1:0] data;
    data = '0;
    data[POS_W-1:0] = pos;
    data[POS_W +: FIELD_IDX_W] = a;
    data[POS_W + FIELD_IDX_W +: FIELD_IDX_W] = b;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 2 * IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= fn;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(fn, data);
  endtask

  task automatic load_point(logic [POS_W-1:0] pos);
    send_beat(FN_LOAD, pos, FIELD_IDX_W'($urandom), FIELD_IDX_W'($urandom));
  endtask

  task automatic build_table();
    send_beat(FN_BUILD, $urandom, FIELD_IDX_W'($urandom), FIELD_IDX_W'($urandom));
  endtask

  task automatic query(logic [FIELD_IDX_W-1:0] a, logic [FIELD_IDX_W-1:0] b);
    send_beat(FN_QUERY, $urandom, a, b);
  endtask

  // wait for the block to go idle before touching the register
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_hop(logic [POS_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.reach = v;
  endtask

  // mostly sorted, now and then a stray value anywhere in the range
  function automatic logic [POS_W-1:0] next_pos();
    if ($urandom_range(0, 39) == 0) return $urandom;
    cursor += $urandom_range(0, step);
    return cursor;
  endfunction

  // queries with some noise: bad indices, unused func, rebuilds, late loads
  task automatic mixed_traffic(int n, int unsigned lo_min);
    int                     r;
    int unsigned            cnt;
    logic [FIELD_IDX_W-1:0] a, b;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      cnt = sb.n_points;
      if (r < 75) begin
        a = FIELD_IDX_W'($urandom_range(lo_min, cnt - 1));
        b = ($urandom_range(0, 9) == 0) ? a : FIELD_IDX_W'($urandom_range(lo_min, cnt - 1));
        query(a, b);
      end else if (r < 85) begin
        query(FIELD_IDX_W'($urandom), FIELD_IDX_W'($urandom));
      end else if (r < 90) begin
        send_beat(FN_UNUSED, $urandom, FIELD_IDX_W'($urandom), FIELD_IDX_W'($urandom));
      end else if (r < 95) begin
        build_table();
      end else begin
        // a load drops the table until the next build
        load_point(next_pos());
        query(FIELD_IDX_W'($urandom_range(0, cnt - 1)), FIELD_IDX_W'($urandom_range(0, cnt - 1)));
        build_table();
      end
    end
  endtask

  initial begin
    int unsigned      fill_start;
    logic [POS_W-1:0] d;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty store, unbuilt table, unused func
    query(0, 0);
    build_table();
    query(0, 0);
    send_beat(FN_UNUSED, '1, '1, '1);
    // duplicates, extremes and an unsorted point
    load_point(32'd0);
    load_point(32'd0);
    load_point(32'd3);
    load_point(32'd10);
    load_point('1);
    load_point(32'd2);
    load_point('1);
    query(1, 0);
    build_table();
    query(0, 0);
    query(3, 0);
    query(0, 6);
    query(6, 0);
    query(1023, 0);
    query(0, 7);
    query(2, 3);
    write_max_hop('1);
    build_table();
    query(0, 6);
    query(5, 1);
    write_max_hop(32'd8);
    build_table();
    query(0, 3);
    query(6, 4);

    cursor = 32'd16;
    for (int p = 0; p < 7; p++) begin
      step = 32'd1 << $urandom_range(0, 16);
      case (p)
        0:       write_max_hop('1);
        1:       write_max_hop('0);
        default: write_max_hop($urandom_range(0, 4 * step));
      endcase
      steady = (p == 3);
      cursor += $urandom_range(0, 1 << 24);
      while (sb.n_points < GROW[p]) load_point(next_pos());
      build_table();
      mixed_traffic(30, 0);
    end
    steady = 0;

    // add evenly spaced points so that long paths appear
    d = $urandom_range(1, 1000);
    write_max_hop(d);
    fill_start = sb.n_points;
    while (sb.n_points < FILL_POINTS) begin
      cursor += d;
      load_point(cursor);
    end
    build_table();
    query(FIELD_IDX_W'(fill_start), FIELD_IDX_W'(FILL_POINTS - 1));
    query(1023, 0);
    mixed_traffic(40, fill_start);
    write_max_hop('0);
    build_table();
    mixed_traffic(10, fill_start);
    write_max_hop(3 * d);
    build_table();
    mixed_traffic(20, fill_start);

    settle();
    repeat (16) @(posedge clk);
    $display("run: %0d beats sent, %0d results checked, store ended at %0d points",
             sb.n_items, sb.n_checked, sb.n_points);
    $display("status mix: ok %0d, range/full %0d, unbuilt %0d, unreachable %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[min_hop_jump_table_top] OK");
    end else begin
      $display("[min_hop_jump_table_top] ERROR");
    end
    $finish;
  end

endmodule
